### sv/nlfs_pkg.sv
// ---------------------------------------------------------------------------
// nlfs_pkg: shared types for the named loop frame stack
// Beat layouts, frame layout, command codes and the per-cell control group.
// ---------------------------------------------------------------------------
package nlfs_pkg;

    localparam int NAME_BYTES          = 7;
    localparam int NAME_W              = 8 * NAME_BYTES;
    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int DEPTH_W             = 7;

    // command codes
    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_POP    = 3'd2,
        CMD_PEEK   = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    // input beat
    typedef struct packed {
        logic [2:0]  cmd;
        logic [55:0] loop_var;
        logic [63:0] target_bits;
        logic [63:0] step_bits;
        logic [31:0] line_no;
        logic [31:0] text_pos;
        logic [31:0] next_pos;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic         ok;
        logic [55:0]  out_name;
        logic [63:0]  out_target;
        logic [63:0]  out_step;
        logic [31:0]  out_lineno;
        logic [31:0]  out_pos;
        logic [31:0]  out_next;
        logic [DEPTH_W-1:0] depth;
    } out_beat_t;

    // one stack frame as held in a cell
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [63:0]       target;
        logic [63:0]       step;
        logic [31:0]       line;
        logic [31:0]       pos;
        logic [31:0]       next;
    } frame_t;

    // control broadcast to every cell
    typedef struct packed {
        logic              search;     // capture compare result
        logic [NAME_W-1:0] key;        // search name
        logic              key_empty;  // empty name selects the top frame
        logic              push_en;    // committed push with room
        logic              upd_en;     // committed update, named
        logic              pop_en;     // committed pop
        logic              any_found;  // some cell matched
    } cell_ctrl_t;

endpackage

### sv/nlfs_cell.sv
// ---------------------------------------------------------------------------
// nlfs_cell: one frame slot of the stack
// Holds a frame, registers its name compare, forwards the found flag and the
// selected frame down the chain, and loads from the slot above on a pop.
// ---------------------------------------------------------------------------
module nlfs_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  nlfs_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    count,
    input  nlfs_pkg::frame_t    wr_frame,
    input  nlfs_pkg::frame_t    frame_above,
    output nlfs_pkg::frame_t    frame_out,
    input  logic                found_in,
    output logic                found_out,
    output logic                sel_out,
    input  nlfs_pkg::frame_t    rd_in,
    output nlfs_pkg::frame_t    rd_out
);
    import nlfs_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    frame_t frame_reg;
    logic   match_reg;
    logic   live;
    logic   is_top;
    logic   hit;
    logic   sel;
    logic   shift;
    logic   push_here;

    // slot status against the current fill
    assign live   = IDX < count;
    assign is_top = (IDX + CNT_W'(1)) == count;
    assign hit    = live && (ctrl.key_empty ? is_top : (frame_reg.name == ctrl.key));

    // registered compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctrl.search) begin
            match_reg <= hit;
        end
    end

    // topmost match: nothing matched above this slot
    assign sel       = match_reg && !found_in;
    assign found_out = found_in || match_reg;
    assign sel_out   = sel;
    assign rd_out    = rd_in | (sel ? frame_reg : '0);

    // pop closes the gap: every slot at or above the removed one moves down
    assign shift     = ctrl.pop_en && ctrl.any_found && !found_in;
    assign push_here = ctrl.push_en && (IDX == count);

    // frame storage
    always_ff @(posedge aclk) begin
        if (push_here) begin
            frame_reg <= wr_frame;
        end else if (shift) begin
            frame_reg <= frame_above;
        end else if (ctrl.upd_en && sel) begin
            frame_reg.target <= wr_frame.target;
            frame_reg.step   <= wr_frame.step;
            frame_reg.next   <= wr_frame.next;
        end
    end

    assign frame_out = frame_reg;

endmodule

### sv/named_loop_frame_stack.sv
// ---------------------------------------------------------------------------
// named_loop_frame_stack: bounded stack of named loop frames
// A row of frame cells searched by name in parallel; push, update, pop,
// peek and clear, one result beat per command.
// ---------------------------------------------------------------------------
//
//  Channel | Ports                      | Beat
//  --------+----------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data   | cmd, name, target, step, line, pos, next
//  result  | m_valid, m_ready, m_data   | ok, frame fields, depth
//
//  A command first registers the per-cell name compares (search state), then
//  resolves the topmost match along the cell chain and commits (exec state).
//  A new beat is taken on the commit edge, so a waiting command goes straight to search.
//  Reset clears the fill count, state, result valid and cell match flags; frame contents are not cleared.
//  The commit waits while the result register holds an untaken beat.
//
module named_loop_frame_stack #(
    parameter int STACK_DEPTH = nlfs_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nlfs_pkg::in_beat_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output nlfs_pkg::out_beat_t m_data
);
    import nlfs_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EXEC   = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    in_beat_t   in_reg;
    out_beat_t  out_reg, out_next;
    logic       m_valid_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    cell_ctrl_t ctrl;
    frame_t     wr_frame;
    frame_t     frames [STACK_DEPTH];
    frame_t     rd     [STACK_DEPTH+1];
    logic [STACK_DEPTH:0]   found;
    logic [STACK_DEPTH-1:0] sel_vec;

    logic [NAME_W-1:0] key;
    logic out_free;
    logic commit;
    logic has_room;
    logic ok;

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_EXEC) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || commit;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    assign key      = in_reg.loop_var[NAME_W-1:0];
    assign has_room = count_reg < FULL;

    // data written by push and update
    always_comb begin
        wr_frame.name   = key;
        wr_frame.target = in_reg.target_bits;
        wr_frame.step   = in_reg.step_bits;
        wr_frame.line   = in_reg.line_no;
        wr_frame.pos    = in_reg.text_pos;
        wr_frame.next   = (in_reg.cmd == CMD_PUSH) ? 32'd0 : in_reg.next_pos;
    end

    // cell control
    always_comb begin
        ctrl.search    = (state_reg == ST_SEARCH);
        ctrl.key       = key;
        ctrl.key_empty = (key == '0);
        ctrl.push_en   = commit && (in_reg.cmd == CMD_PUSH) && has_room;
        ctrl.upd_en    = commit && (in_reg.cmd == CMD_UPDATE) && (key != '0);
        ctrl.pop_en    = commit && (in_reg.cmd == CMD_POP);
        ctrl.any_found = found[0];
    end

    // chain of cells, index 0 at the bottom; found and read data flow down
    assign found[STACK_DEPTH] = 1'b0;
    assign rd[STACK_DEPTH]    = '0;

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        frame_t above;
        if (i == STACK_DEPTH - 1) begin : g_top
            assign above = frames[i];
        end else begin : g_mid
            assign above = frames[i+1];
        end
        nlfs_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .count       (count_reg),
            .wr_frame    (wr_frame),
            .frame_above (above),
            .frame_out   (frames[i]),
            .found_in    (found[i+1]),
            .found_out   (found[i]),
            .sel_out     (sel_vec[i]),
            .rd_in       (rd[i+1]),
            .rd_out      (rd[i])
        );
    end

    // command decode: outcome and new fill
    always_comb begin
        ok         = 1'b0;
        count_next = count_reg;
        unique case (in_reg.cmd)
            CMD_PUSH: begin
                ok = has_room;
                if (has_room) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_UPDATE: begin
                ok = (key != '0) && found[0];
            end
            CMD_POP: begin
                ok = found[0];
                if (found[0]) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_PEEK: begin
                ok = found[0];
            end
            CMD_CLEAR: begin
                ok         = 1'b1;
                count_next = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // result beat
    always_comb begin
        out_next       = '0;
        out_next.ok    = ok;
        out_next.depth = DEPTH_W'(count_next);
        if (ok && ((in_reg.cmd == CMD_POP) || (in_reg.cmd == CMD_PEEK))) begin
            out_next.out_name   = 56'(rd[0].name);
            out_next.out_target = rd[0].target;
            out_next.out_step   = rd[0].step;
            out_next.out_lineno = rd[0].line;
            out_next.out_pos    = rd[0].pos;
            out_next.out_next   = rd[0].next;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next = s_valid ? ST_SEARCH : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (commit) begin
            out_reg <= out_next;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("fill count above stack depth");

    a_single_select: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(sel_vec))
        else $error("more than one cell selected");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (in_reg.cmd == CMD_POP) && found[0])
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("successful pop did not drop one frame");

    a_match_needs_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && found[0]) |-> (count_reg != '0))
        else $error("match reported on empty stack");

endmodule
